// ===== rtl/sl_pkg.sv =====
package sl_pkg;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam int QDEPTH = 4;
  localparam int QIDX = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] text_offset;
    logic [15:0] text_length;
    logic        final_token;
  } out_item_t;

  // Token kinds
  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_BOOL   = 6'd1;
  localparam logic [5:0] K_INT    = 6'd2;
  localparam logic [5:0] K_REAL   = 6'd3;
  localparam logic [5:0] K_STRING = 6'd4;
  localparam logic [5:0] K_ERROR  = 6'd5;
  localparam logic [5:0] K_DOTDOT = 6'd6;
  localparam logic [5:0] K_SINGLE = 6'd18;
  localparam logic [5:0] K_END    = 6'd35;

  // Character classes computed in the front end
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       alpha;
    logic       digit;
    logic       hex;
    logic       space;
    logic       opens_pair;
    logic [5:0] single;
  } cls_t;

  // Clip a position-width value to the 16-bit output field
  function automatic logic [15:0] clip16(input logic [POS_BITS-1:0] x);
    logic [15:0] r;
    if (POS_BITS > 16 && (x >> 16) != '0) r = 16'hFFFF;
    else r = 16'(x);
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] x);
    return (x == POS_MAX) ? x : x + POS_BITS'(1);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+": k = K_SINGLE + 6'd0;
      "-": k = K_SINGLE + 6'd1;
      "*": k = K_SINGLE + 6'd2;
      "/": k = K_SINGLE + 6'd3;
      "&": k = K_SINGLE + 6'd4;
      "|": k = K_SINGLE + 6'd5;
      "^": k = K_SINGLE + 6'd6;
      "~": k = K_SINGLE + 6'd7;
      "!": k = K_SINGLE + 6'd8;
      "<": k = K_SINGLE + 6'd9;
      ">": k = K_SINGLE + 6'd10;
      "=": k = K_SINGLE + 6'd11;
      "?": k = K_SINGLE + 6'd12;
      ":": k = K_SINGLE + 6'd13;
      "(": k = K_SINGLE + 6'd14;
      ")": k = K_SINGLE + 6'd15;
      ";": k = K_SINGLE + 6'd16;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  // Two-character operator kind; K_ERROR when the pair is not an operator
  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = K_ERROR;
    if (a == "." && b == ".") k = K_DOTDOT;
    else if (a == "&" && b == "&") k = K_DOTDOT + 6'd1;
    else if (a == "|" && b == "|") k = K_DOTDOT + 6'd2;
    else if (b == "=") begin
      case (a)
        "=": k = K_DOTDOT + 6'd3;
        "!": k = K_DOTDOT + 6'd4;
        "<": k = K_DOTDOT + 6'd5;
        ">": k = K_DOTDOT + 6'd6;
        ":": k = K_DOTDOT + 6'd7;
        "+": k = K_DOTDOT + 6'd8;
        "-": k = K_DOTDOT + 6'd9;
        "*": k = K_DOTDOT + 6'd10;
        "/": k = K_DOTDOT + 6'd11;
        default: k = K_ERROR;
      endcase
    end
    return k;
  endfunction

  function automatic logic [7:0] kw_next(input logic [3:0] m);
    logic [7:0] r;
    case (m)
      4'd1: r = "r";
      4'd2: r = "u";
      4'd3: r = "e";
      4'd5: r = "a";
      4'd6: r = "l";
      4'd7: r = "s";
      4'd8: r = "e";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sl_front.sv =====
module sl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sl_pkg::in_item_t in_data,
  output logic             q_valid,
  input  logic             q_pop,
  output sl_pkg::cls_t     q_data
);
  import sl_pkg::*;

  cls_t            mem_r [QDEPTH];
  logic [QIDX-1:0] wp_r, rp_r;
  logic [QIDX:0]   cnt_r;
  cls_t            cls;
  logic            push;
  logic [7:0]      c;

  // Classify the incoming byte
  always_comb begin
    c = in_data.byte_value;
    cls.ch         = c;
    cls.eoi        = in_data.end_of_input;
    cls.alpha      = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    cls.digit      = (c >= "0" && c <= "9");
    cls.hex        = cls.digit || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    cls.space      = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    cls.opens_pair = (c == ".") || (c == "&") || (c == "|") || (c == "=") ||
                     (c == "!") || (c == "<") || (c == ">") || (c == ":") ||
                     (c == "+") || (c == "-") || (c == "*") || (c == "/");
    cls.single     = single_kind(c);
  end

  assign in_stall = (cnt_r == (QIDX+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QIDX'(1);
      if (q_pop) rp_r <= rp_r + QIDX'(1);
      cnt_r <= cnt_r + (QIDX+1)'(push) - (QIDX+1)'(q_pop);
    end
  end

endmodule

// ===== rtl/sl_back.sv =====
module sl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  sl_pkg::cls_t      q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sl_pkg::out_item_t out_data
);
  import sl_pkg::*;

  typedef enum logic [14:0] {
    M_IDLE     = 15'b000000000000001,
    M_IDENT    = 15'b000000000000010,
    M_STRING   = 15'b000000000000100,
    M_ZERO     = 15'b000000000001000,
    M_DEC_INT  = 15'b000000000010000,
    M_DEC_DOT  = 15'b000000000100000,
    M_FRAC     = 15'b000000001000000,
    M_EXP_E    = 15'b000000010000000,
    M_EXP_SIGN = 15'b000000100000000,
    M_EXP_DIG  = 15'b000001000000000,
    M_GARBAGE  = 15'b000010000000000,
    M_TRAIL    = 15'b000100000000000,
    M_HEX_X    = 15'b001000000000000,
    M_HEX_DIG  = 15'b010000000000000,
    M_OP       = 15'b100000000000000
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  beg_r, beg_nxt;
  logic [POS_BITS-1:0]  len_r, len_nxt;
  logic [POS_BITS-1:0]  dot_r, dot_nxt;
  logic [7:0]           held_r, held_nxt;
  logic [3:0]           kw_r, kw_nxt;

  // Two-entry result buffer; slot 0 is shown at the output
  out_item_t            buf_r [2];
  logic [1:0]           bcnt_r;
  out_item_t            e0, e1;
  logic [1:0]           n;
  logic                 take;
  logic                 pop_out;

  logic [7:0]           c;
  logic                 ident_ch, ident_st;
  logic [5:0]           pk;

  assign pop_out   = out_valid && !out_stall;
  assign out_valid = (bcnt_r != 2'd0);
  assign out_data  = buf_r[0];
  // Take a new byte only when room for two results remains after this cycle
  assign take  = q_valid && ((bcnt_r == 2'd0) || (bcnt_r == 2'd1 && pop_out));
  assign q_pop = take;

  function automatic out_item_t mk(input logic [5:0] k, input logic [POS_BITS-1:0] s,
                                   input logic [POS_BITS-1:0] o,
                                   input logic [POS_BITS-1:0] l, input logic f);
    out_item_t r;
    r.token_kind  = k;
    r.token_start = clip16(s);
    r.text_offset = clip16(o);
    r.text_length = clip16(l);
    r.final_token = f;
    return r;
  endfunction

  // Lexer state update for one byte
  always_comb begin
    logic    do_flush, do_idle, tail, tail_exp;
    logic [5:0] tail_kind;
    mode_t   fm;
    mode_nxt = mode_r;
    pos_nxt  = sat_inc(pos_r);
    beg_nxt  = beg_r;
    len_nxt  = len_r;
    dot_nxt  = dot_r;
    held_nxt = held_r;
    kw_nxt   = kw_r;
    e0 = '0;
    e1 = '0;
    n  = 2'd0;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    tail     = 1'b0;
    tail_exp = 1'b0;
    tail_kind = K_INT;
    fm = mode_r;
    c = q_data.ch;
    ident_ch = q_data.alpha || q_data.digit || (c == "_");
    ident_st = q_data.alpha || (c == "_") || (c == "@");
    pk = pair_kind(held_r, c);

    if (q_data.eoi) begin
      do_flush = 1'b1;
    end else begin
      case (mode_r)
        M_IDENT: begin
          if (ident_ch) begin
            if (kw_r < 4'd10 && kw_next(kw_r) != 8'd0 && c == kw_next(kw_r))
              kw_nxt = kw_r + 4'd1;
            else
              kw_nxt = 4'd15;
            len_nxt = sat_inc(len_r);
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_STRING: begin
          if (c == "'") begin
            e0 = mk(K_STRING, beg_r, sat_inc(beg_r), len_r - POS_BITS'(1), 1'b0);
            n = 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            len_nxt = sat_inc(len_r);
          end
        end
        M_ZERO, M_DEC_INT: begin
          if (mode_r == M_ZERO && (c == "x" || c == "X")) begin
            mode_nxt = M_HEX_X;
            len_nxt = sat_inc(len_r);
          end else if (q_data.digit) begin
            mode_nxt = M_DEC_INT;
            len_nxt = sat_inc(len_r);
          end else if (c == ".") begin
            dot_nxt = pos_r;
            mode_nxt = M_DEC_DOT;
            len_nxt = sat_inc(len_r);
          end else begin
            tail = 1'b1;
            tail_exp = 1'b1;
            tail_kind = K_INT;
          end
        end
        M_DEC_DOT: begin
          if (c == ".") begin
            e0 = mk(K_INT, beg_r, beg_r, len_r - POS_BITS'(1), 1'b0);
            e1 = mk(K_DOTDOT, dot_r, dot_r, POS_BITS'(2), 1'b0);
            n = 2'd2;
            mode_nxt = M_IDLE;
          end else if (q_data.digit) begin
            mode_nxt = M_FRAC;
            len_nxt = sat_inc(len_r);
          end else if (ident_ch) begin
            mode_nxt = M_GARBAGE;
            len_nxt = sat_inc(len_r);
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_FRAC: begin
          if (q_data.digit) begin
            len_nxt = sat_inc(len_r);
          end else begin
            tail = 1'b1;
            tail_exp = 1'b1;
            tail_kind = K_REAL;
          end
        end
        M_EXP_E, M_EXP_SIGN: begin
          if (mode_r == M_EXP_E && (c == "+" || c == "-")) begin
            mode_nxt = M_EXP_SIGN;
            len_nxt = sat_inc(len_r);
          end else if (q_data.digit) begin
            mode_nxt = M_EXP_DIG;
            len_nxt = sat_inc(len_r);
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_EXP_DIG: begin
          if (q_data.digit) begin
            len_nxt = sat_inc(len_r);
          end else begin
            tail = 1'b1;
            tail_kind = K_REAL;
          end
        end
        M_TRAIL, M_GARBAGE: begin
          if (ident_ch || (mode_r == M_GARBAGE && c == ".")) begin
            len_nxt = sat_inc(len_r);
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_HEX_X, M_HEX_DIG: begin
          if (q_data.hex) begin
            mode_nxt = M_HEX_DIG;
            len_nxt = sat_inc(len_r);
          end else if (c == "." || ident_ch) begin
            mode_nxt = M_GARBAGE;
            len_nxt = sat_inc(len_r);
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_OP: begin
          if (pk != K_ERROR) begin
            e0 = mk(pk, beg_r, beg_r, POS_BITS'(2), 1'b0);
            n = 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    // Number tail: exponent, error on '@', trailing letters, or end of the number
    if (tail) begin
      if (tail_exp && (c == "e" || c == "E")) begin
        mode_nxt = M_EXP_E;
        len_nxt = sat_inc(len_r);
      end else if (c == "@") begin
        e0 = mk(K_ERROR, beg_r, beg_r, len_r, 1'b0);
        n = 2'd1;
        mode_nxt = M_IDLE;
        do_idle = 1'b1;
      end else if (ident_st) begin
        mode_nxt = M_TRAIL;
        len_nxt = sat_inc(len_r);
      end else begin
        e0 = mk(tail_kind, beg_r, beg_r, len_r, 1'b0);
        n = 2'd1;
        mode_nxt = M_IDLE;
        do_idle = 1'b1;
      end
    end

    // Flush the pending token
    if (do_flush) begin
      n = 2'd1;
      mode_nxt = M_IDLE;
      case (fm)
        M_IDENT:
          e0 = mk((kw_r == 4'd4 || kw_r == 4'd9) ? K_BOOL : K_IDENT,
                  beg_r, beg_r, len_r, 1'b0);
        M_ZERO, M_DEC_INT:
          e0 = mk(K_INT, beg_r, beg_r, len_r, 1'b0);
        M_HEX_DIG:
          e0 = mk(K_INT, beg_r, beg_r, len_r, 1'b0);
        M_FRAC, M_EXP_DIG:
          e0 = mk(K_REAL, beg_r, beg_r, len_r, 1'b0);
        M_OP:
          e0 = mk(single_kind(held_r), beg_r, beg_r, POS_BITS'(1), 1'b0);
        M_IDLE:
          n = 2'd0;
        default:
          e0 = mk(K_ERROR, beg_r, beg_r, len_r, 1'b0);
      endcase
    end

    // End marker: end token, then restart the stream
    if (q_data.eoi) begin
      if (n == 2'd0) e0 = mk(K_END, pos_r, pos_r, '0, 1'b1);
      else e1 = mk(K_END, pos_r, pos_r, '0, 1'b1);
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
      beg_nxt  = '0;
      len_nxt  = '0;
      dot_nxt  = '0;
      held_nxt = '0;
      kw_nxt   = '0;
    end else if (do_idle) begin
      // Scan the byte afresh from the idle state
      mode_nxt = M_IDLE;
      if (q_data.space) begin
        mode_nxt = M_IDLE;
      end else if (c == "'") begin
        mode_nxt = M_STRING;
        beg_nxt = pos_r;
        len_nxt = POS_BITS'(1);
      end else if (q_data.digit) begin
        mode_nxt = (c == "0") ? M_ZERO : M_DEC_INT;
        beg_nxt = pos_r;
        len_nxt = POS_BITS'(1);
      end else if (ident_st) begin
        mode_nxt = M_IDENT;
        beg_nxt = pos_r;
        len_nxt = POS_BITS'(1);
        kw_nxt = (c == "t") ? 4'd1 : (c == "f") ? 4'd5 : 4'd15;
      end else if (q_data.opens_pair) begin
        mode_nxt = M_OP;
        beg_nxt = pos_r;
        len_nxt = POS_BITS'(1);
        held_nxt = c;
      end else begin
        if (n == 2'd0) e0 = mk(q_data.single, pos_r, pos_r, POS_BITS'(1), 1'b0);
        else e1 = mk(q_data.single, pos_r, pos_r, POS_BITS'(1), 1'b0);
        n = n + 2'd1;
      end
    end
  end

  // Lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      beg_r  <= '0;
      len_r  <= '0;
      dot_r  <= '0;
      held_r <= '0;
      kw_r   <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      beg_r  <= beg_nxt;
      len_r  <= len_nxt;
      dot_r  <= dot_nxt;
      held_r <= held_nxt;
      kw_r   <= kw_nxt;
    end
  end

  // Result buffer: drop the shown transfer, append new results behind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 2'd0;
    end else begin
      bcnt_r <= bcnt_r - {1'b0, pop_out} + (take ? n : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (bcnt_r == 2'd0 || pop_out) begin
        if (n != 2'd0) buf_r[0] <= e0;
        buf_r[1] <= e1;
      end
    end else if (pop_out) begin
      buf_r[0] <= buf_r[1];
    end
  end

endmodule

// ===== rtl/script_lexer.sv =====
// A byte's tokens pass through the queue register, then the result register;
// a token ends only on a later byte.
// Throughput: one byte per cycle while the queue and the output do not stall; a byte
// yielding two tokens holds the back end while the single output port drains the result buffer.
// Reset (rst_n low, synchronous): queue and results empty, position zero, idle.
module script_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sl_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sl_pkg::out_item_t out_data
);
  import sl_pkg::*;

  logic q_valid, q_pop;
  cls_t q_data;

  sl_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  sl_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ===== test/script_lexer_tb.sv =====
module script_lexer_tb;
  import sl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_IDENT, S_STRING, S_ZERO, S_DEC_INT, S_DEC_DOT, S_FRAC, S_EXP_E, S_EXP_SIGN,
    S_EXP_DIG, S_GARBAGE, S_TRAIL, S_HEX_X, S_HEX_DIG, S_OP
  } lex_mode_t;

  localparam int LIMIT = 400000;

  // Predict tokens from bytes and check them against the block's output.
  class token_board;
    out_item_t pending_tokens[$];
    int errors;
    lex_mode_t mode;
    logic [POS_BITS-1:0] cur_pos, tok_begin, tok_len, dot_pos;
    logic [7:0] held;
    logic [3:0] kw;

    function void clear();
      mode = S_IDLE;
      cur_pos = '0;
      tok_begin = '0;
      tok_len = '0;
      dot_pos = '0;
      held = '0;
      kw = '0;
    endfunction

    function logic [POS_BITS-1:0] inc(logic [POS_BITS-1:0] x);
      return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    function logic [15:0] clip(logic [POS_BITS-1:0] x);
      return (x > 'hFFFF) ? 16'hFFFF : 16'(x);
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit hexd(logic [7:0] c);
      return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function bit id_start(logic [7:0] c);
      return alpha(c) || c == "_" || c == "@";
    endfunction

    function bit id_char(logic [7:0] c);
      return alpha(c) || digit(c) || c == "_";
    endfunction

    function logic [5:0] lone_op(logic [7:0] c);
      case (c)
        "+": return K_SINGLE + 6'd0;
        "-": return K_SINGLE + 6'd1;
        "*": return K_SINGLE + 6'd2;
        "/": return K_SINGLE + 6'd3;
        "&": return K_SINGLE + 6'd4;
        "|": return K_SINGLE + 6'd5;
        "^": return K_SINGLE + 6'd6;
        "~": return K_SINGLE + 6'd7;
        "!": return K_SINGLE + 6'd8;
        "<": return K_SINGLE + 6'd9;
        ">": return K_SINGLE + 6'd10;
        "=": return K_SINGLE + 6'd11;
        "?": return K_SINGLE + 6'd12;
        ":": return K_SINGLE + 6'd13;
        "(": return K_SINGLE + 6'd14;
        ")": return K_SINGLE + 6'd15;
        ";": return K_SINGLE + 6'd16;
        default: return K_ERROR;
      endcase
    endfunction

    // Return the two-character operator index, or -1.
    function int duo_index(logic [7:0] a, logic [7:0] b);
      string firsts;
      firsts = ".&|=!<>:+-*/";
      for (int k = 0; k < 12; k++) begin
        if (a == firsts[k]) begin
          if (k < 3) return (b == a) ? k : -1;
          return (b == "=") ? k : -1;
        end
      end
      return -1;
    endfunction

    function void push(logic [5:0] kind, logic [POS_BITS-1:0] st, logic [POS_BITS-1:0] off,
                       logic [POS_BITS-1:0] len, logic fin);
      out_item_t t;
      t.token_kind = kind;
      t.token_start = clip(st);
      t.text_offset = clip(off);
      t.text_length = clip(len);
      t.final_token = fin;
      pending_tokens = {pending_tokens, t};
    endfunction

    function void close_tok(logic [5:0] kind);
      push(kind, tok_begin, tok_begin, tok_len, 1'b0);
      mode = S_IDLE;
    endfunction

    function void open_tok(lex_mode_t m);
      mode = m;
      tok_begin = cur_pos;
      tok_len = 1;
    endfunction

    function void grow(lex_mode_t m);
      mode = m;
      tok_len = inc(tok_len);
    endfunction

    function void scan_fresh(logic [7:0] c);
      bit pair_open;
      pair_open = duo_index(c, ".") >= 0 || duo_index(c, c) >= 0 || duo_index(c, "=") >= 0;
      if (c == " " || c == "\t" || c == "\n" || c == "\r") return;
      if (c == "'") open_tok(S_STRING);
      else if (digit(c)) open_tok(c == "0" ? S_ZERO : S_DEC_INT);
      else if (id_start(c)) begin
        open_tok(S_IDENT);
        kw = (c == "t") ? 4'd1 : (c == "f") ? 4'd5 : 4'd15;
      end else if (pair_open) begin
        open_tok(S_OP);
        held = c;
      end else push(lone_op(c), cur_pos, cur_pos, 1, 1'b0);
    endfunction

    function void num_tail(logic [7:0] c, logic [5:0] kind, bit exp_ok);
      if (exp_ok && (c == "e" || c == "E")) grow(S_EXP_E);
      else if (c == "@") begin
        close_tok(K_ERROR);
        scan_fresh(c);
      end else if (id_start(c)) grow(S_TRAIL);
      else begin
        close_tok(kind);
        scan_fresh(c);
      end
    endfunction

    function void flush_tok();
      case (mode)
        S_IDENT: close_tok((kw == 4 || kw == 9) ? K_BOOL : K_IDENT);
        S_ZERO, S_DEC_INT, S_HEX_DIG: close_tok(K_INT);
        S_FRAC, S_EXP_DIG: close_tok(K_REAL);
        S_OP: push(lone_op(held), tok_begin, tok_begin, 1, 1'b0);
        S_IDLE: ;
        default: close_tok(K_ERROR);
      endcase
      mode = S_IDLE;
    endfunction

    // Next letter of "true" (from 1) or "false" (from 5), zero past the end
    function logic [7:0] kw_want(logic [3:0] m);
      case (m)
        4'd1: return "r";
        4'd2: return "u";
        4'd3: return "e";
        4'd5: return "a";
        4'd6: return "l";
        4'd7: return "s";
        4'd8: return "e";
        default: return 8'd0;
      endcase
    endfunction

    // Note one accepted input transfer.
    function void note_input(in_item_t it);
      logic [7:0] c;
      int k;
      c = it.byte_value;
      if (it.end_of_input) begin
        flush_tok();
        push(K_END, cur_pos, cur_pos, 0, 1'b1);
        clear();
        return;
      end
      case (mode)
        S_IDENT:
          if (id_char(c)) begin
            if (kw < 10 && kw_want(kw) != 0 && c == kw_want(kw)) kw++;
            else kw = 15;
            grow(S_IDENT);
          end else begin
            flush_tok();
            scan_fresh(c);
          end
        S_STRING:
          if (c == "'") begin
            push(K_STRING, tok_begin, inc(tok_begin), tok_len - 1'b1, 1'b0);
            mode = S_IDLE;
          end else grow(S_STRING);
        S_ZERO, S_DEC_INT:
          if (mode == S_ZERO && (c == "x" || c == "X")) grow(S_HEX_X);
          else if (digit(c)) grow(S_DEC_INT);
          else if (c == ".") begin
            dot_pos = cur_pos;
            grow(S_DEC_DOT);
          end else num_tail(c, K_INT, 1);
        S_DEC_DOT:
          if (c == ".") begin
            push(K_INT, tok_begin, tok_begin, tok_len - 1'b1, 1'b0);
            push(K_DOTDOT, dot_pos, dot_pos, 2, 1'b0);
            mode = S_IDLE;
          end else if (digit(c)) grow(S_FRAC);
          else if (id_char(c)) grow(S_GARBAGE);
          else begin
            close_tok(K_ERROR);
            scan_fresh(c);
          end
        S_FRAC:
          if (digit(c)) grow(S_FRAC);
          else num_tail(c, K_REAL, 1);
        S_EXP_E, S_EXP_SIGN:
          if (mode == S_EXP_E && (c == "+" || c == "-")) grow(S_EXP_SIGN);
          else if (digit(c)) grow(S_EXP_DIG);
          else begin
            close_tok(K_ERROR);
            scan_fresh(c);
          end
        S_EXP_DIG:
          if (digit(c)) grow(S_EXP_DIG);
          else num_tail(c, K_REAL, 0);
        S_TRAIL, S_GARBAGE:
          if (id_char(c) || (mode == S_GARBAGE && c == ".")) grow(mode);
          else begin
            close_tok(K_ERROR);
            scan_fresh(c);
          end
        S_HEX_X, S_HEX_DIG:
          if (hexd(c)) grow(S_HEX_DIG);
          else if (c == "." || id_char(c)) grow(S_GARBAGE);
          else begin
            close_tok(mode == S_HEX_DIG ? K_INT : K_ERROR);
            scan_fresh(c);
          end
        S_OP: begin
          k = duo_index(held, c);
          if (k >= 0) begin
            push(K_DOTDOT + 6'(k), tok_begin, tok_begin, 2, 1'b0);
            mode = S_IDLE;
          end else begin
            flush_tok();
            scan_fresh(c);
          end
        end
        default: begin
          mode = S_IDLE;
          scan_fresh(c);
        end
      endcase
      cur_pos = inc(cur_pos);
    endfunction

    // Check one accepted result transfer against the oldest prediction.
    function void check_token(out_item_t got);
      out_item_t exp_tok;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token kind=%0d start=%0d", got.token_kind, got.token_start);
        errors++;
        return;
      end
      exp_tok = pending_tokens.pop_front();
      if (got.token_kind !== exp_tok.token_kind) begin
        $error("token_kind: expected %0d, got %0d", exp_tok.token_kind, got.token_kind);
        errors++;
      end
      if (got.token_start !== exp_tok.token_start) begin
        $error("token_start: expected %0d, got %0d", exp_tok.token_start, got.token_start);
        errors++;
      end
      if (got.text_offset !== exp_tok.text_offset) begin
        $error("text_offset: expected %0d, got %0d", exp_tok.text_offset, got.text_offset);
        errors++;
      end
      if (got.text_length !== exp_tok.text_length) begin
        $error("text_length: expected %0d, got %0d", exp_tok.text_length, got.text_length);
        errors++;
      end
      if (got.final_token !== exp_tok.final_token) begin
        $error("final_token: expected %0d, got %0d", exp_tok.final_token, got.final_token);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  int cycles = 0;
  token_board board;
  in_item_t src_bytes[$];

  script_lexer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Note transfers on both channels and count cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) board.note_input(in_data);
    if (rst_n && out_valid && !out_stall) board.check_token(out_data);
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stall the result channel on a changing pattern, with calm stretches.
  always @(posedge clk) begin
    if (((cycles / 300) % 3) == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Append one item to the source stream.
  task automatic queue_item(in_item_t b);
    src_bytes = {src_bytes, b};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item('{byte_value: s[i], end_of_input: 1'b0});
  endtask

  task automatic add_end();
    queue_item('{byte_value: 8'($urandom), end_of_input: 1'b1});
  endtask

  // Build a random fragment of source text, well-formed or not.
  function automatic string random_lexeme();
    string pool[$];
    string s;
    int n;
    pool = '{"true", "false", "tru", "falsey", "x_1", "@ab", "'hi'", "''", "0x1F", "0xg",
             "65..", "65.x", "3.25", "1e5", "2E-3", "1e+", "7ab", "12@q", "0x9.", "'open",
             "..", "&&", "||", "==", "!=", "<=", ">=", ":=", "+=", "-=", "*=", "/=", "+",
             "-", "*", "/", "&", "|", "^", "~", "!", "<", ">", "=", "?", ":", "(", ")",
             ";", ".", "#", " ", "\t", "\n", "\r", "0", "9.5e1", "1.2.3"};
    s = pool[$urandom_range(0, pool.size() - 1)];
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
    end
    return s;
  endfunction

  initial begin
    in_item_t it;
    board = new();
    board.clear();
    board.errors = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: keywords, numbers, strings, operators, error cases.
    add_text("true false x 'ab' 0x1F 3.5e-2 65..");
    add_end();
    add_text("65.x 1e+ 7ab 12@q 0xz 0x9. != :=;");
    queue_item('{byte_value: 8'hFF, end_of_input: 1'b0});
    queue_item('{byte_value: 8'h00, end_of_input: 1'b0});
    add_text(". 'open");
    add_end();
    add_end();

    // Random part: mostly well-formed fragments, some raw byte noise and end markers.
    while (src_bytes.size() < 470) begin
      case ($urandom_range(0, 9))
        0: queue_item('{byte_value: 8'($urandom), end_of_input: 1'b0});
        1: if ($urandom_range(0, 3) == 0) add_end();
        default: begin
          add_text(random_lexeme());
          if ($urandom_range(0, 1)) add_text(" ");
        end
      endcase
    end
    add_end();

    // Send in bursts with random gaps.
    while (src_bytes.size() > 0) begin
      int burst;
      burst = $urandom_range(1, 12);
      while (burst > 0 && src_bytes.size() > 0) begin
        it = src_bytes.pop_front();
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst--;
      end
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain and let the pipeline settle.
    while (board.pending_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending_tokens.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sl_pkg.sv
rtl/sl_front.sv
rtl/sl_back.sv
rtl/script_lexer.sv
test/script_lexer_tb.sv
